/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL modules.
// Each macro wraps a concurrent assertion clocked on i_clk and held off
// while the synchronous reset i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every clock edge outside reset.
`define SIT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication in the same cycle.
`define SIT_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (prop)) else $error(msg);

// Implication checked in the cycle after the condition.
`define SIT_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

/* sv/sit_pkg.sv */
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types, codes and constants of the sorted insert table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

    // Default number of cells in the chain.
    localparam int CAPACITY_DEF = 16;

    // Fixed field widths.
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;
    localparam int OP_W    = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // One input item.
    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
    } t_in;

    // One result item.
    typedef struct packed {
        logic signed [VALUE_W-1:0] item_value;
        logic                      item_last;
        logic signed [VALUE_W-1:0] first_value;
        logic signed [VALUE_W-1:0] last_value;
        logic                      table_empty;
        logic                      insert_dropped;
        logic [COUNT_W-1:0]        entry_count;
    } t_out;

    // Controls broadcast to every cell.
    typedef struct packed {
        logic                      ins_en;
        logic                      rot_en;
        logic signed [VALUE_W-1:0] ins_value;
    } t_cell_ctrl;

    // Position of one cell relative to the fill level.
    typedef struct packed {
        logic occupied;
        logic tail_slot;
        logic is_last;
    } t_cell_pos;

endpackage

`default_nettype wire

/* sv/sit_cell.sv */
// ----------------------------------------------------------------------------
// sit_cell
// One storage cell of the sorted chain. It compares the offered value with
// its own entry and holds, takes the new value, takes its left neighbour's
// entry (insert shift) or its right neighbour's or the head entry (rotation).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sit_cell (
    input  wire                                    i_clk,
    input  wire sit_pkg::t_cell_ctrl               i_ctrl,
    input  wire sit_pkg::t_cell_pos                i_pos,
    input  wire logic signed [sit_pkg::VALUE_W-1:0] i_prev_value,
    input  wire logic                              i_prev_less,
    input  wire logic signed [sit_pkg::VALUE_W-1:0] i_next_value,
    input  wire logic signed [sit_pkg::VALUE_W-1:0] i_head_value,
    output logic signed [sit_pkg::VALUE_W-1:0]     o_value,
    output logic                                   o_less
);

    logic signed [sit_pkg::VALUE_W-1:0] r_value;
    logic signed [sit_pkg::VALUE_W-1:0] n_value;

    // The new value goes before this entry only when strictly smaller, so
    // equal values keep their arrival order.
    assign o_less  = i_pos.occupied && (i_ctrl.ins_value < r_value);
    assign o_value = r_value;

    // Next entry for insert shifting or for rotation during a dump.
    always_comb begin
        n_value = r_value;
        if (i_ctrl.ins_en) begin
            if (i_prev_less) begin
                n_value = i_prev_value;
            end else if (o_less || i_pos.tail_slot) begin
                n_value = i_ctrl.ins_value;
            end
        end else if (i_ctrl.rot_en) begin
            if (i_pos.is_last) begin
                n_value = i_head_value;
            end else if (i_pos.occupied) begin
                n_value = i_next_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

/* sv/sorted_insert_table.sv */
// ----------------------------------------------------------------------------
// sorted_insert_table
// Bounded table of signed values kept in ascending order in a chain of
// cells. Inserts are stable for equal values, inserts into a full table are
// refused and flagged, a dump emits every entry in order, a query reports
// the smallest and largest entry.
//
//   Channel   Signals                 Direction  Handshake
//   command   start, busy, i_in       in         start && !busy
//   result    o_strobe, o_result      out        o_strobe, one cycle
//
// Insert and query can follow back to back; the result appears on the
// cycle after the transfer.
// A dump of N entries holds busy while the chain rotates by one cell per
// cycle, emitting cell 0 each cycle; the rotation restores the order after
// N steps. An empty dump leaves busy low and returns a single result.
// Reset is synchronous and clears the fill count and the control state only.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_insert_table #(
    parameter int CAPACITY = sit_pkg::CAPACITY_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    input  wire sit_pkg::t_in i_in,
    output logic             busy,
    output logic             o_strobe,
    output sit_pkg::t_out    o_result
);

    `include "assert_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    // Control and bookkeeping registers.
    logic                               r_state,  n_state;
    logic [CW-1:0]                      r_count,  n_count;
    logic [CW-1:0]                      r_idx,    n_idx;
    logic signed [sit_pkg::VALUE_W-1:0] r_first,  n_first;
    logic signed [sit_pkg::VALUE_W-1:0] r_last,   n_last;
    logic                               r_strobe, n_strobe;
    sit_pkg::t_out                      r_result, n_result;

    // Chain signals.
    sit_pkg::t_cell_ctrl                cell_ctrl;
    sit_pkg::t_cell_pos                 cell_pos [CAPACITY];
    logic signed [sit_pkg::VALUE_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]                less_vec;

    logic accept;
    logic full;
    logic empty;
    logic any_less;
    logic head_slot;

    assign busy     = (r_state == ST_DUMP);
    assign accept   = start && !busy;
    assign full     = (r_count == CW'(CAPACITY));
    assign empty    = (r_count == '0);
    assign any_less = |less_vec;
    assign head_slot = empty || less_vec[0];

    // Broadcast controls to the cells.
    always_comb begin
        cell_ctrl.ins_en    = accept && (i_in.op == sit_pkg::OP_INSERT) && !full;
        cell_ctrl.rot_en    = (r_state == ST_DUMP);
        cell_ctrl.ins_value = i_in.value;
    end

    // The chain of cells.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign cell_pos[g].occupied  = (CW'(g) < r_count);
        assign cell_pos[g].tail_slot = (CW'(g) == r_count);
        assign cell_pos[g].is_last   = (CW'(g) + CW'(1) == r_count);

        if (g == 0) begin : g_head
            sit_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (cell_ctrl),
                .i_pos        (cell_pos[g]),
                .i_prev_value ('0),
                .i_prev_less  (1'b0),
                .i_next_value (cell_value[(g + 1) % CAPACITY]),
                .i_head_value (cell_value[0]),
                .o_value      (cell_value[g]),
                .o_less       (less_vec[g])
            );
        end else if (g == CAPACITY - 1) begin : g_tail
            sit_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (cell_ctrl),
                .i_pos        (cell_pos[g]),
                .i_prev_value (cell_value[g - 1]),
                .i_prev_less  (less_vec[g - 1]),
                .i_next_value (cell_value[g]),
                .i_head_value (cell_value[0]),
                .o_value      (cell_value[g]),
                .o_less       (less_vec[g])
            );
        end else begin : g_mid
            sit_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (cell_ctrl),
                .i_pos        (cell_pos[g]),
                .i_prev_value (cell_value[g - 1]),
                .i_prev_less  (less_vec[g - 1]),
                .i_next_value (cell_value[g + 1]),
                .i_head_value (cell_value[0]),
                .o_value      (cell_value[g]),
                .o_less       (less_vec[g])
            );
        end
    end

    // Command decode, dump sequencing and result formation.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_first  = r_first;
        n_last   = r_last;
        n_strobe = 1'b0;

        n_result.item_value     = '0;
        n_result.item_last      = 1'b1;
        n_result.first_value    = empty ? '0 : r_first;
        n_result.last_value     = empty ? '0 : r_last;
        n_result.table_empty    = empty;
        n_result.insert_dropped = 1'b0;
        n_result.entry_count    = sit_pkg::COUNT_W'(r_count);

        if (r_state == ST_DUMP) begin
            // Emit the head cell while the chain rotates by one place.
            n_strobe                = 1'b1;
            n_result.item_value     = cell_value[0];
            n_result.item_last      = (r_idx + CW'(1) == r_count);
            n_idx                   = r_idx + CW'(1);
            if (r_idx + CW'(1) == r_count) begin
                n_state = ST_IDLE;
            end
        end else if (accept) begin
            case (i_in.op)
                sit_pkg::OP_INSERT: begin
                    n_strobe            = 1'b1;
                    n_result.item_value = i_in.value;
                    if (full) begin
                        n_result.insert_dropped = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                        n_first = head_slot ? i_in.value : r_first;
                        n_last  = any_less ? r_last : i_in.value;
                        n_result.first_value = n_first;
                        n_result.last_value  = n_last;
                        n_result.table_empty = 1'b0;
                        n_result.entry_count = sit_pkg::COUNT_W'(n_count);
                    end
                end
                sit_pkg::OP_DUMP: begin
                    if (empty) begin
                        n_strobe = 1'b1;
                    end else begin
                        n_state = ST_DUMP;
                        n_idx   = '0;
                    end
                end
                sit_pkg::OP_QUERY: begin
                    n_strobe = 1'b1;
                end
                default: begin
                    n_strobe = 1'b0;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_last   <= n_last;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // The fill count never passes the number of cells.
    `SIT_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "fill count above capacity")

    // The dump index stays within the stored entries.
    `SIT_ASSERT_IMPL(a_dump_idx, r_state == ST_DUMP, r_idx < r_count,
        "dump index beyond stored entries")

    // An accepted insert into a table with room grows it by one.
    `SIT_ASSERT_NEXT(a_insert_grows,
        accept && (i_in.op == sit_pkg::OP_INSERT) && !full,
        r_count == $past(r_count) + CW'(1), "insert did not grow the table")

    // A refused insert is only reported when the table is full.
    `SIT_ASSERT_IMPL(a_drop_full, o_strobe && o_result.insert_dropped,
        r_count == CW'(CAPACITY), "insert dropped on a table with room")

endmodule

`default_nettype wire
